/* sv/mexp_pkg.sv */
package mexp_pkg;

	// Operand width; products fit in twice this.
	localparam int WIDTH = 32;
	localparam int PROD_W = 2 * WIDTH;
	localparam int CNT_W = $clog2(PROD_W);
	localparam int CFG_IDX_W = 8;
	localparam int PORT_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = CFG_IDX_W'(1);

	// Control shared by every cell of the reduction row.
	typedef struct packed {
		logic clr;
		logic sub;
	} cell_ctrl_t;

endpackage

/* sv/mexp_if.sv */
interface mexp_in_if import mexp_pkg::*; ();
	logic valid;
	logic ready;
	logic [PORT_W-1:0] message_in;
	modport source (output valid, output message_in, input ready);
	modport sink (input valid, input message_in, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
	logic valid;
	logic ready;
	logic [PORT_W-1:0] result_value;
	logic zero_modulus_error;
	modport source (output valid, output result_value, output zero_modulus_error, input ready);
	modport sink (input valid, input result_value, input zero_modulus_error, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [PORT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/modular_exponentiation.sv */
// Channel  Dir  Payload                                 Handshake
// msg      in   message_in                              valid / ready
// res      out  result_value, zero_modulus_error        valid / ready
// cfg      in   index, data (0 exponent, 1 modulus)     valid / ready (always ready)
//
// A request walks the exponent from its lowest bit up to its highest set bit. A set bit
// costs a multiply and a square, a clear bit a square only, and the multiply for the
// highest set bit ends the walk without a square.
// Each modular product is formed by the multiplier and then passes through the row of
// remainder cells, one product bit per cycle.
// A zero modulus goes from idle straight to the finish state with a flagged zero result;
// exponent zero goes from idle through the step state to the finish state. Reset (arst_n
// low) sets the exponent to one and the modulus to zero. A finished result stalls while
// the output register is still full.
module modular_exponentiation import mexp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mexp_in_if.sink    msg,
	mexp_out_if.source res,
	mexp_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {S_IDLE, S_STEP, S_RED, S_WB, S_FIN} state_t;
	typedef enum logic {OP_MUL, OP_SQR} op_t;

	state_t state_q;
	op_t op_q;

	// Configuration registers.
	logic [PORT_W-1:0] exp_cfg_q;
	logic [PORT_W-1:0] mod_cfg_q;

	// Working registers for the current request.
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] acc_q;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] fin_q;
	logic fin_err_q;

	// Output register.
	logic out_valid_q;
	logic [WIDTH-1:0] result_q;
	logic err_q;

	logic [WIDTH-1:0] mod_w;
	logic [WIDTH-1:0] mul_a;
	logic [PROD_W-1:0] mul_p;
	logic [WIDTH-1:0] rem;
	// The finished result moves into the output register in this cycle.
	logic fin_take;

	// The remainder row: WIDTH+1 cells, the top one catching the bit shifted
	// out of the remainder before the subtraction brings it back below the modulus.
	cell_ctrl_t ctrl;
	logic [WIDTH:0] cell_bit;
	logic [WIDTH+1:0] borrow;
	logic [WIDTH:0] cell_shift;
	logic [WIDTH:0] cell_mod;

	assign mod_w = mod_cfg_q[WIDTH-1:0];
	assign borrow[0] = 1'b0;
	assign cell_shift = {cell_bit[WIDTH-1:0], prod_q[PROD_W-1]};
	assign cell_mod = {1'b0, mod_w};
	assign ctrl.clr = (state_q != S_RED);
	// No borrow out of the top cell means the shifted remainder is at least the modulus.
	assign ctrl.sub = ~borrow[WIDTH+1];
	assign rem = cell_bit[WIDTH-1:0];

	for (genvar i = 0; i <= WIDTH; i++) begin : g_cell
		mexp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.shift_in   (cell_shift[i]),
			.mod_bit    (cell_mod[i]),
			.borrow_in  (borrow[i]),
			.bit_out    (cell_bit[i]),
			.borrow_out (borrow[i+1])
		);
	end

	// The one multiplier: accumulator times base, or base squared.
	assign mul_a = (state_q == S_STEP && e_q[0]) ? acc_q : base_q;
	assign mul_p = mul_a * base_q;

	assign fin_take = (state_q == S_FIN) && (!out_valid_q || res.ready);

	assign msg.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign res.valid = out_valid_q;
	assign res.result_value = PORT_W'(result_q);
	assign res.zero_modulus_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cfg_q <= PORT_W'(1);
			mod_cfg_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_EXPONENT) begin
				exp_cfg_q <= cfg.data;
			end else if (cfg.index == REG_MODULUS) begin
				mod_cfg_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_MUL;
			out_valid_q <= 1'b0;
			result_q <= '0;
			err_q <= 1'b0;
			e_q <= '0;
			base_q <= '0;
			acc_q <= '0;
			prod_q <= '0;
			cnt_q <= '0;
			fin_q <= '0;
			fin_err_q <= 1'b0;
		end else begin
			if (fin_take) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (msg.valid) begin
						if (mod_w == '0) begin
							fin_q <= '0;
							fin_err_q <= 1'b1;
							state_q <= S_FIN;
						end else begin
							base_q <= msg.message_in[WIDTH-1:0];
							acc_q <= WIDTH'(1);
							e_q <= exp_cfg_q[WIDTH-1:0];
							fin_err_q <= 1'b0;
							state_q <= S_STEP;
						end
					end
				end
				S_STEP: begin
					if (e_q == '0) begin
						// Exponent zero: the accumulator still holds an unreduced one.
						fin_q <= acc_q;
						state_q <= S_FIN;
					end else begin
						op_q <= e_q[0] ? OP_MUL : OP_SQR;
						prod_q <= mul_p;
						cnt_q <= '0;
						state_q <= S_RED;
					end
				end
				S_RED: begin
					prod_q <= prod_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (op_q == OP_MUL) begin
						acc_q <= rem;
						if (e_q[WIDTH-1:1] == '0) begin
							fin_q <= rem;
							state_q <= S_FIN;
						end else begin
							op_q <= OP_SQR;
							prod_q <= mul_p;
							cnt_q <= '0;
							state_q <= S_RED;
						end
					end else begin
						base_q <= rem;
						e_q <= e_q >> 1;
						state_q <= S_STEP;
					end
				end
				S_FIN: begin
					if (fin_take) begin
						result_q <= fin_q;
						err_q <= fin_err_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// A flagged result always carries zero.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.zero_modulus_error |-> res.result_value == '0)
		else $error("zero modulus result is not zero");

	// Every reduction leaves a remainder below the modulus.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB |-> rem < mod_w)
		else $error("remainder not below modulus");

	// A reduction always runs its full count before write-back.
	a_red_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB |-> $past(state_q) == S_RED && $past(cnt_q) == CNT_W'(PROD_W - 1))
		else $error("write-back without a complete reduction");
`endif

endmodule

/* sv/mexp_cell.sv */
// One bit of the partial remainder. Unless cleared, each cycle it takes its
// lower neighbour's bit (a shift left), subtracts its modulus bit with the
// rippling borrow and keeps the difference if the whole row says it fits.
module mexp_cell import mexp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       shift_in,
	input  logic       mod_bit,
	input  logic       borrow_in,
	output logic       bit_out,
	output logic       borrow_out
);

	logic bit_q;
	logic diff;

	assign diff = shift_in ^ mod_bit ^ borrow_in;
	assign borrow_out = (~shift_in & mod_bit) | (~(shift_in ^ mod_bit) & borrow_in);
	assign bit_out = bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctrl.clr) begin
			bit_q <= 1'b0;
		end else begin
			bit_q <= ctrl.sub ? diff : shift_in;
		end
	end

endmodule
